// ===== design/fractal_value_noise_3d_macros.svh =====
// assertion macros for the fractal value noise block
// no dependencies; taken in by the files that carry assertions
`ifndef FRACTAL_VALUE_NOISE_3D_MACROS_SVH
`define FRACTAL_VALUE_NOISE_3D_MACROS_SVH
`ifndef SYNTHESIS
`define FVN_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fvn3d assertion failed");
`define FVN_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fvn3d assertion failed");
`else
`define FVN_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define FVN_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== design/fvn3d_pkg.sv =====
// shared constants, types and table functions of the fractal value noise block
// no dependencies
package fvn3d_pkg;

  localparam int MAX_OCTAVES_DEF = 8;
  localparam int COSINE_TABLE_DEPTH_DEF = 256;
  localparam int FRACTION_BITS_DEF = 16;

  localparam int COORD_W = 28;
  localparam int NOISE_W = 21;
  localparam int COUNT_W = 4;
  localparam int GAIN_W = 18;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 18;

  localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_COUNT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_GAIN = 4'd1;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd5;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 18'd81920;

  localparam int HASH_POINTS = 64;
  localparam int HASH_AW = 6;

  localparam logic [31:0] HASH_MUL = 32'd1366224802;
  localparam logic [31:0] HASH_ADD = 32'd429496730;
  localparam logic [18:0] W_CENTRE = 19'd419430;
  localparam logic [18:0] W_FACE = 19'd41943;
  localparam logic [18:0] W_OTHER = 19'd18874;
  localparam logic [NOISE_W-1:0] OUT_MAX = 21'd2097151;
  localparam logic [40:0] WEIGHT_CAP = 41'h100_0000_0000;
  localparam logic [40:0] WEIGHT_ONE = 41'd65536;

  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam longint ONE_Q30 = 64'd1073741824;

  typedef struct packed {
    logic        valid;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [HASH_AW-1:0] addr;
  } hash_req_t;

  typedef struct packed {
    logic        busy;
    logic        we;
    logic [HASH_AW-1:0] addr;
    logic [31:0] data;
  } hash_wr_t;

  function automatic longint cos_q30(longint unsigned x);
    longint unsigned x2;
    longint unsigned term;
    longint unsigned Den;
    longint sum;
    x2 = (x * x) >> 30;
    term = 64'(ONE_Q30);
    sum = ONE_Q30;
    for (int k = 1; k <= 12; k++) begin
      Den = 64'((2 * k - 1) * (2 * k));
      term = ((term * x2) >> 30) / Den;
      if (k % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > ONE_Q30) sum = ONE_Q30;
    return sum;
  endfunction

  function automatic logic [16:0] ease_entry(int unsigned k, int unsigned Depth);
    longint f30;
    longint unsigned q;
    if (2 * k <= Depth) begin
      f30 = (ONE_Q30 - cos_q30((PI_Q30 * 64'(k)) / 64'(Depth))) / 2;
    end else begin
      f30 = (ONE_Q30 + cos_q30((PI_Q30 * 64'(Depth - k)) / 64'(Depth))) / 2;
    end
    q = (64'(f30) + 64'd8192) >> 14;
    if (q > 64'd65536) q = 64'd65536;
    return 17'(q);
  endfunction

  function automatic logic [15:0] blend(logic [15:0] a, logic [15:0] b, logic [16:0] e);
    logic [33:0] p;
    p = 34'(a) * 34'(17'd65536 - e) + 34'(b) * 34'(e);
    return 16'(p >> 16);
  endfunction

endpackage

// ===== design/fvn3d_coord_if.sv =====
// input item channel: one signed fixed-point point
// depends on fvn3d_pkg
interface fvn3d_coord_if;
  logic valid;
  logic ready;
  logic [fvn3d_pkg::COORD_W-1:0] coord_x;
  logic [fvn3d_pkg::COORD_W-1:0] coord_y;
  logic [fvn3d_pkg::COORD_W-1:0] coord_z;
  modport source (output valid, coord_x, coord_y, coord_z, input ready);
  modport sink (input valid, coord_x, coord_y, coord_z, output ready);
endinterface

// ===== design/fvn3d_noise_if.sv =====
// result item channel: one noise sum
// depends on fvn3d_pkg
interface fvn3d_noise_if;
  logic valid;
  logic ready;
  logic [fvn3d_pkg::NOISE_W-1:0] noise_value;
  modport source (output valid, noise_value, input ready);
  modport sink (input valid, noise_value, output ready);
endinterface

// ===== design/fvn3d_cfg_if.sv =====
// configuration write channel: register index and data
// depends on fvn3d_pkg
interface fvn3d_cfg_if;
  logic valid;
  logic ready;
  logic [fvn3d_pkg::CFG_IDX_W-1:0] index;
  logic [fvn3d_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/fvn3d_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module fvn3d_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== design/fvn3d_hash.sv =====
// pipelined lattice hash: one lattice point in per cycle, hash write out
// depends on fvn3d_pkg
module fvn3d_hash (
  input  logic                 clk,
  input  logic                 rst,
  input  fvn3d_pkg::hash_req_t req,
  output fvn3d_pkg::hash_wr_t  wr
);
  logic [3:0] vld;
  logic [fvn3d_pkg::HASH_AW-1:0] addr1, addr2, addr3, addr4;
  logic [31:0] ax, ay, az;
  logic [31:0] apx, apy, apz;
  logic [20:0] qx, qy, qz, qz3;
  logic [25:0] p3;
  logic [22:0] qs3, qs4;
  logic [30:0] m4;

  assign apx = ax + fvn3d_pkg::HASH_ADD;
  assign apy = ay + fvn3d_pkg::HASH_ADD;
  assign apz = az + fvn3d_pkg::HASH_ADD;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[2:0], req.valid};
    end
    ax <= 32'(req.x * fvn3d_pkg::HASH_MUL);
    ay <= 32'(req.y * fvn3d_pkg::HASH_MUL);
    az <= 32'(req.z * fvn3d_pkg::HASH_MUL);
    addr1 <= req.addr;
    qx <= 21'((37'(apx) * 37'd17) >> 16);
    qy <= 21'((37'(apy) * 37'd17) >> 16);
    qz <= 21'((37'(apz) * 37'd17) >> 16);
    addr2 <= addr1;
    p3 <= 26'((42'(qx) * 42'(qy)) >> 16);
    qs3 <= 23'(qx) + 23'(qy) + 23'(qz);
    qz3 <= qz;
    addr3 <= addr2;
    m4 <= 31'((47'(p3) * 47'(qz3)) >> 16);
    qs4 <= qs3;
    addr4 <= addr3;
  end

  assign wr.busy = |vld;
  assign wr.we = vld[3];
  assign wr.addr = addr4;
  assign wr.data = 32'(54'(m4) * 54'(qs4));
endmodule

// ===== design/fractal_value_noise_3d.sv =====
// top level of the fractal value noise block: sequencer, smoothing and octave sum
// depends on fvn3d_pkg, the three channel interfaces, fvn3d_hash, fvn3d_ram
// and fractal_value_noise_3d_macros.svh
//
// usage: a point enters on coord (valid/ready); one noise_value leaves on noise
// for each point, in order. cfg writes octave_count (index 0) and octave_gain
// (index 1); it is always ready, and it is to be written only while the block
// is idle: the block itself does not enforce this. each octave hashes the 64
// lattice points around the cell into a 64-entry hash memory, waits for the
// hash pipeline to drain, then smooths the eight corners by 216 reads of that
// memory (one read port, one read a cycle), then blends and accumulates.
// octaves run one after another. an input register takes the next point
// while the current one is worked on; an output register holds the result
// while the receiver stalls, and the next result waits in the sequencer
// until it is taken.
// reset (rst, synchronous) empties both registers, returns the sequencer to
// idle and loads octave_count 5 and octave_gain 1.25; no clearing pass.
`include "fractal_value_noise_3d_macros.svh"
module fractal_value_noise_3d #(
  parameter int MAX_OCTAVES = fvn3d_pkg::MAX_OCTAVES_DEF,
  parameter int COSINE_TABLE_DEPTH = fvn3d_pkg::COSINE_TABLE_DEPTH_DEF,
  parameter int FRACTION_BITS = fvn3d_pkg::FRACTION_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  fvn3d_coord_if.sink         coord,
  fvn3d_noise_if.source       noise,
  fvn3d_cfg_if.sink           cfg
);
  localparam int OW = $clog2(MAX_OCTAVES + 1);
  localparam int IW = $clog2(COSINE_TABLE_DEPTH);
  localparam int SW = FRACTION_BITS + 32;
  localparam int SD = (FRACTION_BITS >= 16) ? FRACTION_BITS - 16 : 0;
  localparam int SU = (FRACTION_BITS >= 16) ? 0 : 16 - FRACTION_BITS;
  localparam int CW = fvn3d_pkg::COORD_W;

  typedef enum logic [10:0] {
    ST_IDLE   = 11'b000_0000_0001,
    ST_SETUP  = 11'b000_0000_0010,
    ST_HASH   = 11'b000_0000_0100,
    ST_HWAIT  = 11'b000_0000_1000,
    ST_SMOOTH = 11'b000_0001_0000,
    ST_SWAIT  = 11'b000_0010_0000,
    ST_BLZ    = 11'b000_0100_0000,
    ST_BLY    = 11'b000_1000_0000,
    ST_BLX    = 11'b001_0000_0000,
    ST_TERM   = 11'b010_0000_0000,
    ST_DONE   = 11'b100_0000_0000
  } state_t;

  state_t state;

  logic in_full;
  logic [CW-1:0] in_v [3];
  logic [CW-1:0] v [3];
  logic [fvn3d_pkg::COUNT_W-1:0] octave_count;
  logic [fvn3d_pkg::GAIN_W-1:0] octave_gain;
  logic [OW-1:0] count_eff, count_lat, oct;

  logic [SW-1:0] sh_c [3];
  logic [15:0] t16_c [3];
  logic [31:0] prod_c [3];
  logic [31:0] lat_base [3];
  logic [IW-1:0] idx [3];
  logic [16:0] ease [3];
  logic [16:0] ease_rom [COSINE_TABLE_DEPTH];

  logic [fvn3d_pkg::HASH_AW-1:0] pcnt;
  fvn3d_pkg::hash_req_t hreq;
  fvn3d_pkg::hash_wr_t hwr;

  logic [2:0] corner;
  logic [1:0] dx, dy, dz;
  logic [1:0] nzc;
  logic [18:0] wsel;
  logic issue_last;
  logic [fvn3d_pkg::HASH_AW-1:0] raddr;
  logic [31:0] rdata;

  logic t1_v, t1_first, t1_last, t2_v, t2_first, t2_last;
  logic [2:0] t1_corner, t2_corner;
  logic [18:0] t1_w;
  logic [50:0] t2_prod;
  logic [55:0] acc, acc_next;

  logic [15:0] cval [8];
  logic [15:0] bz [4];
  logic [15:0] by [2];
  logic [15:0] nval;
  logic [40:0] term, weight;
  logic [58:0] wprod;
  logic [41:0] tsum;
  logic [fvn3d_pkg::NOISE_W-1:0] total;

  logic out_valid;
  logic [fvn3d_pkg::NOISE_W-1:0] out_value;

  for (genvar g = 0; g < COSINE_TABLE_DEPTH; g++) begin : g_ease
    assign ease_rom[g] = fvn3d_pkg::ease_entry(g, COSINE_TABLE_DEPTH);
  end

  assign coord.ready = !in_full;
  assign noise.valid = out_valid;
  assign noise.noise_value = out_value;
  assign cfg.ready = 1'b1;

  always_comb begin
    if (octave_count == '0) count_eff = OW'(1);
    else if (5'(octave_count) > 5'(MAX_OCTAVES)) count_eff = OW'(MAX_OCTAVES);
    else count_eff = OW'(octave_count);
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sh_c[a] = {{(SW - CW){v[a][CW-1]}}, v[a]} << oct;
      t16_c[a] = 16'((32'(sh_c[a][FRACTION_BITS-1:0]) >> SD) << SU);
      prod_c[a] = 32'(t16_c[a]) * 32'(COSINE_TABLE_DEPTH);
    end
  end

  always_comb begin
    hreq.valid = (state == ST_HASH);
    hreq.x = lat_base[0] + 32'(pcnt[5:4]) - 32'd1;
    hreq.y = lat_base[1] + 32'(pcnt[3:2]) - 32'd1;
    hreq.z = lat_base[2] + 32'(pcnt[1:0]) - 32'd1;
    hreq.addr = pcnt;
  end

  fvn3d_hash u_hash (
    .clk (clk),
    .rst (rst),
    .req (hreq),
    .wr  (hwr)
  );

  assign raddr = {2'({1'b0, corner[2]} + dx), 2'({1'b0, corner[1]} + dy),
                  2'({1'b0, corner[0]} + dz)};

  fvn3d_ram #(.WIDTH(32), .DEPTH(fvn3d_pkg::HASH_POINTS)) u_hash_ram (
    .clk   (clk),
    .we    (hwr.we),
    .waddr (hwr.addr),
    .wdata (hwr.data),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    nzc = 2'(dx != 2'd1) + 2'(dy != 2'd1) + 2'(dz != 2'd1);
    case (nzc)
      2'd0: wsel = fvn3d_pkg::W_CENTRE;
      2'd1: wsel = fvn3d_pkg::W_FACE;
      default: wsel = fvn3d_pkg::W_OTHER;
    endcase
    issue_last = (dx == 2'd2) && (dy == 2'd2) && (dz == 2'd2);
    acc_next = t2_first ? 56'(t2_prod) : acc + 56'(t2_prod);
    wprod = 59'(weight) * 59'(octave_gain);
    tsum = 42'(total) + 42'(term);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      in_full <= 1'b0;
      out_valid <= 1'b0;
      octave_count <= fvn3d_pkg::COUNT_RESET;
      octave_gain <= fvn3d_pkg::GAIN_RESET;
      oct <= '0;
      count_lat <= OW'(1);
      pcnt <= '0;
      corner <= '0;
      dx <= '0;
      dy <= '0;
      dz <= '0;
      t1_v <= 1'b0;
      t2_v <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          fvn3d_pkg::REG_OCTAVE_COUNT: octave_count <= cfg.data[fvn3d_pkg::COUNT_W-1:0];
          fvn3d_pkg::REG_OCTAVE_GAIN: octave_gain <= cfg.data;
          default: ;
        endcase
      end
      if (coord.valid && !in_full) in_full <= 1'b1;
      if (out_valid && noise.ready) out_valid <= 1'b0;

      t1_v <= (state == ST_SMOOTH);
      t1_first <= (dx == 2'd0) && (dy == 2'd0) && (dz == 2'd0);
      t1_last <= issue_last;
      t1_corner <= corner;
      t1_w <= wsel;
      t2_v <= t1_v;
      t2_first <= t1_first;
      t2_last <= t1_last;
      t2_corner <= t1_corner;
      t2_prod <= 51'(t1_w) * 51'(rdata);
      if (t2_v) begin
        acc <= acc_next;
        if (t2_last) cval[t2_corner] <= acc_next[51:36];
      end

      case (state)
        ST_IDLE: begin
          if (in_full) begin
            in_full <= 1'b0;
            oct <= '0;
            count_lat <= count_eff;
            weight <= fvn3d_pkg::WEIGHT_ONE;
            total <= '0;
            state <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          pcnt <= '0;
          state <= ST_HASH;
        end
        ST_HASH: begin
          pcnt <= pcnt + 1'b1;
          if (pcnt == 6'(fvn3d_pkg::HASH_POINTS - 1)) state <= ST_HWAIT;
        end
        ST_HWAIT: begin
          corner <= '0;
          dx <= '0;
          dy <= '0;
          dz <= '0;
          if (!hwr.busy) state <= ST_SMOOTH;
        end
        ST_SMOOTH: begin
          if (dz != 2'd2) begin
            dz <= dz + 1'b1;
          end else begin
            dz <= '0;
            if (dy != 2'd2) begin
              dy <= dy + 1'b1;
            end else begin
              dy <= '0;
              if (dx != 2'd2) begin
                dx <= dx + 1'b1;
              end else begin
                dx <= '0;
                corner <= corner + 1'b1;
                if (corner == 3'd7) state <= ST_SWAIT;
              end
            end
          end
        end
        ST_SWAIT: begin
          if (!t1_v && !t2_v) state <= ST_BLZ;
        end
        ST_BLZ: begin
          for (int i = 0; i < 4; i++) begin
            bz[i] <= fvn3d_pkg::blend(cval[2*i], cval[2*i+1], ease[2]);
          end
          state <= ST_BLY;
        end
        ST_BLY: begin
          by[0] <= fvn3d_pkg::blend(bz[0], bz[1], ease[1]);
          by[1] <= fvn3d_pkg::blend(bz[2], bz[3], ease[1]);
          state <= ST_BLX;
        end
        ST_BLX: begin
          nval <= fvn3d_pkg::blend(by[0], by[1], ease[0]);
          state <= ST_TERM;
        end
        ST_TERM: begin
          term <= 41'((57'(nval) * 57'(weight)) >> 16);
          if ((wprod >> 16) > 59'(fvn3d_pkg::WEIGHT_CAP)) weight <= fvn3d_pkg::WEIGHT_CAP;
          else weight <= 41'(wprod >> 16);
          state <= ST_DONE;
          oct <= oct + 1'b1;
        end
        ST_DONE: begin
          if (oct != '0 && tsum > 42'(fvn3d_pkg::OUT_MAX)) total <= fvn3d_pkg::OUT_MAX;
          else total <= fvn3d_pkg::NOISE_W'(tsum);
          if (oct < count_lat) begin
            state <= ST_SETUP;
          end else if (!out_valid || noise.ready) begin
            out_valid <= 1'b1;
            out_value <= (tsum > 42'(fvn3d_pkg::OUT_MAX)) ? fvn3d_pkg::OUT_MAX
                                                          : fvn3d_pkg::NOISE_W'(tsum);
            state <= ST_IDLE;
          end else begin
            term <= '0;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (coord.valid && !in_full) begin
      in_v[0] <= coord.coord_x;
      in_v[1] <= coord.coord_y;
      in_v[2] <= coord.coord_z;
    end
    if (state == ST_IDLE && in_full) begin
      v <= in_v;
    end
    if (state == ST_SETUP) begin
      for (int a = 0; a < 3; a++) begin
        lat_base[a] <= sh_c[a][FRACTION_BITS+31:FRACTION_BITS];
        idx[a] <= IW'(prod_c[a] >> 16);
      end
    end
    if (state == ST_HASH) begin
      for (int a = 0; a < 3; a++) begin
        ease[a] <= ease_rom[idx[a]];
      end
    end
  end

  `FVN_ASSERT_NOW(a_no_write_in_smooth, clk, rst, state == ST_SMOOTH, !hwr.we)
  `FVN_ASSERT_NOW(a_octave_in_range, clk, rst, state == ST_SETUP, oct < count_lat)
  `FVN_ASSERT_NEXT(a_done_loads_out, clk, rst,
                   state == ST_DONE && !out_valid && oct >= count_lat, out_valid)
endmodule
